// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the min/max stack.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/mms_pkg.sv =====
// Types and constants of the min/max stack.
// No dependencies; used by mms_ctrl, mms_dpath and min_max_stack.
package mms_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP      = 2'd1,
    ACT_LARGEST  = 2'd2,
    ACT_SMALLEST = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_LARGEST  = 2'd0,
    STAT_SMALLEST = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } state_t;

  localparam int unsigned REG_MAX_FLOOR   = 0;
  localparam int unsigned REG_MIN_CEILING = 1;

  localparam logic signed [31:0] MAX_FLOOR_RST   = -32'sd1000000;
  localparam logic signed [31:0] MIN_CEILING_RST = 32'sd1000000;

  typedef struct packed {
    logic    push;      // write new top entry
    logic    pop;       // drop top, start read of entry below
    logic    load;      // take read data as new top
    logic    res_load;  // capture a result word
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sts_t;

endpackage

// ===== rtl/min_max_stack.sv =====
// Min/max stack: push, pop, largest and smallest queries on signed 32-bit words.
// A pop also reads the entry below from memory and stalls the input while it reloads the top.
// A result word is registered and appears the cycle after its command.
// Synchronous active-low reset empties the stack and restores floor/ceiling;
// memory contents are not cleared. Depends on mms_pkg, mms_ctrl, mms_dpath and assert_macros.svh.
`include "assert_macros.svh"
module min_max_stack #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_answer,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  mms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  mms_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_push_value (in_push_value),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .out_answer    (out_answer),
    .out_status    (out_status)
  );

  // pop reload blocks the next word in the cycle after the pop
  `ASSERT_RST(a_pop_blocks, clk, rst_n, cmd.pop |=> in_stall)
  // a dropped push shows up as a full status word
  `ASSERT_RST(a_full_result, clk, rst_n,
    (in_valid && !in_stall && (in_action == ACT_PUSH) && sts.full) |=>
    (out_valid && (out_status == STAT_FULL) && (out_answer == 32'sd0)))
  `ASSERT_RST(a_no_push_pop_full_empty, clk, rst_n,
    !(cmd.push && sts.full) && !(cmd.pop && sts.empty))

endmodule

// ===== rtl/mms_ctrl.sv =====
// Controller of the min/max stack: accept logic, pop reload sequencing,
// output valid. Depends on mms_pkg.
module mms_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_action,
  output logic           in_stall,
  input  logic           out_stall,
  output logic           out_valid,
  input  mms_pkg::sts_t  sts,
  output mms_pkg::cmd_t  cmd
);
  import mms_pkg::*;

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  action_t act;
  logic    produces;
  logic    accept;

  assign act = action_t'(in_action);

  always_comb begin
    case (act)
      ACT_PUSH:                produces = sts.full;
      ACT_LARGEST, ACT_SMALLEST: produces = !sts.empty;
      default:                 produces = 1'b0;
    endcase
  end

  // Output register frees up in the same cycle it is taken.
  assign in_stall = (state_r == ST_LOAD) || (produces && out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd            = '0;
    cmd.res_status = STAT_FULL;
    cmd.push       = accept && (act == ACT_PUSH) && !sts.full;
    cmd.pop        = accept && (act == ACT_POP) && !sts.empty;
    cmd.load       = (state_r == ST_LOAD);
    cmd.res_load   = accept && produces;
    case (act)
      ACT_LARGEST:  cmd.res_status = STAT_LARGEST;
      ACT_SMALLEST: cmd.res_status = STAT_SMALLEST;
      default:      cmd.res_status = STAT_FULL;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd.pop) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.res_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/mms_dpath.sv =====
// Datapath of the min/max stack: running max/min memories, top registers,
// fill count, config registers and result register. Depends on mms_pkg.
module mms_dpath #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mms_pkg::cmd_t       cmd,
  output mms_pkg::sts_t       sts,
  input  logic signed [31:0]  in_push_value,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic signed [31:0]  out_answer,
  output logic [1:0]          out_status
);
  import mms_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic signed [31:0] max_mem [STACK_DEPTH];
  logic signed [31:0] min_mem [STACK_DEPTH];

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] top_max_r, top_max_nxt;
  logic signed [31:0] top_min_r, top_min_nxt;
  logic signed [31:0] rd_max_r, rd_min_r;
  logic signed [31:0] floor_r, ceil_r;
  logic signed [31:0] answer_r, answer_nxt;
  status_t            status_r;
  logic [CW-1:0]      rd_idx;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic signed [31:0] push_max, push_min;
  logic               cfg_wr;

  assign sts.empty = (cnt_r == '0);
  assign sts.full  = (cnt_r == CW'(STACK_DEPTH));

  // entry below the current top becomes the new top on pop
  assign rd_idx  = cnt_r - CW'(2);
  assign rd_addr = rd_idx[AW-1:0];
  assign wr_addr = cnt_r[AW-1:0];

  always_comb begin
    push_max = in_push_value;
    push_min = in_push_value;
    if (!sts.empty) begin
      if (top_max_r > in_push_value) push_max = top_max_r;
      if (top_min_r < in_push_value) push_min = top_min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      max_mem[wr_addr] <= push_max;
      min_mem[wr_addr] <= push_min;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_max_r <= max_mem[rd_addr];
      rd_min_r <= min_mem[rd_addr];
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    top_max_nxt = top_max_r;
    top_min_nxt = top_min_r;
    if (cmd.push) begin
      cnt_nxt     = cnt_r + CW'(1);
      top_max_nxt = push_max;
      top_min_nxt = push_min;
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.load) begin
      top_max_nxt = rd_max_r;
      top_min_nxt = rd_min_r;
    end
  end

  always_comb begin
    case (cmd.res_status)
      STAT_LARGEST:  answer_nxt = (top_max_r < floor_r) ? floor_r : top_max_r;
      STAT_SMALLEST: answer_nxt = (top_min_r > ceil_r) ? ceil_r : top_min_r;
      default:       answer_nxt = '0;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      floor_r <= MAX_FLOOR_RST;
      ceil_r  <= MIN_CEILING_RST;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_wr && (paddr[2] == 1'(REG_MAX_FLOOR)))   floor_r <= pwdata;
      if (cfg_wr && (paddr[2] == 1'(REG_MIN_CEILING))) ceil_r  <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    top_max_r <= top_max_nxt;
    top_min_r <= top_min_nxt;
    if (cmd.res_load) begin
      answer_r <= answer_nxt;
      status_r <= cmd.res_status;
    end
  end

  assign prdata     = (paddr[2] == 1'(REG_MIN_CEILING)) ? ceil_r : floor_r;
  assign out_answer = answer_r;
  assign out_status = status_r;

endmodule
